>>> rtl/core/hsp_pkg.sv
// Shared constants and types of the hash to sparse positions block.
// Used by every module in rtl/core except hsp_ram; depends on nothing else.
package hsp_pkg;

    localparam int POS_W       = 10;
    localparam int VECTOR_SIZE = 1024;
    localparam int WORD_W      = 32;
    localparam int COUNT_W     = 6;
    localparam int GROUPS      = 3;
    localparam int GROUP_WORDS = 5;
    localparam int LIST_DEPTH  = 64;
    localparam int LIST_AW     = 6;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = 2;
    localparam int FIFO_CW     = 3;
    localparam int SLOTS       = 6;
    localparam int REM_W       = 3;
    localparam int WORD_SLOTS  = 3;
    localparam int FINAL_SLOTS = 7;
    localparam int M_DATA_W    = 16;
    localparam int M_USER_W    = 2;

    localparam logic [COUNT_W-1:0] TARGET_RESET = 6'd32;

    typedef enum logic [1:0] {
        TOK_PLAIN,
        TOK_FINAL,
        TOK_FINISH
    } tok_kind_t;

    typedef struct packed {
        logic             valid;
        tok_kind_t        kind;
        logic [POS_W-1:0] pos;
    } token_t;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic             position_valid;
        logic             last;
        logic             failed;
    } result_t;

    typedef struct packed {
        logic busy;
        logic clear_done;
    } mark_status_t;

endpackage

>>> rtl/core/hsp_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies; contents are undefined until written.
module hsp_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/core/hsp_feed.sv
// Input stage: accepts hash words, collects the extra candidates and issues one candidate token
// per cycle towards the bitmap stage while the queue has room and no reset clear runs. Depends on hsp_pkg.
module hsp_feed (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [hsp_pkg::WORD_W-1:0]   s_tdata,
    input  logic                         room,
    input  hsp_pkg::mark_status_t        mark_status,
    output hsp_pkg::token_t              token
);
    import hsp_pkg::*;

    logic [POS_W-1:0] slot_reg  [SLOTS];
    logic [POS_W-1:0] slot_next [SLOTS];
    logic [POS_W-1:0] extra_reg  [GROUPS];
    logic [POS_W-1:0] extra_next [GROUPS];
    logic [REM_W-1:0] rem_reg, rem_next;
    logic             final_reg, final_next;
    logic             wait_reg, wait_next;
    logic [1:0]       grp_reg, grp_next;
    logic [2:0]       idx_reg, idx_next;
    logic             issue;
    logic             accept;
    logic             is_final_word;

    always_comb
    begin
        issue         = (rem_reg != '0) && room && !mark_status.busy;
        s_tready      = !wait_reg && !mark_status.busy
                        && ((rem_reg == '0) || ((rem_reg == REM_W'(1)) && issue));
        accept        = s_tvalid && s_tready;
        is_final_word = (grp_reg == 2'(GROUPS));

        token.valid = issue;
        token.pos   = slot_reg[0];
        if (final_reg && (rem_reg == REM_W'(1)))
        begin
            token.kind = TOK_FINISH;
        end
        else if (final_reg)
        begin
            token.kind = TOK_FINAL;
        end
        else
        begin
            token.kind = TOK_PLAIN;
        end
    end

    always_comb
    begin
        slot_next  = slot_reg;
        extra_next = extra_reg;
        rem_next   = rem_reg;
        final_next = final_reg;
        wait_next  = wait_reg;
        grp_next   = grp_reg;
        idx_next   = idx_reg;

        if (issue)
        begin
            for (int i = 0; i < SLOTS - 1; i++)
            begin
                slot_next[i] = slot_reg[i + 1];
            end
            rem_next = rem_reg - REM_W'(1);
        end

        if (accept)
        begin
            slot_next[0] = s_tdata[POS_W-1:0];
            slot_next[1] = s_tdata[2*POS_W-1:POS_W];
            slot_next[2] = s_tdata[3*POS_W-1:2*POS_W];
            for (int g = 0; g < GROUPS; g++)
            begin
                slot_next[WORD_SLOTS + g] = extra_reg[g];
            end
            final_next = is_final_word;
            if (is_final_word)
            begin
                rem_next  = REM_W'(FINAL_SLOTS);
                wait_next = 1'b1;
                grp_next  = '0;
                idx_next  = '0;
                for (int g = 0; g < GROUPS; g++)
                begin
                    extra_next[g] = '0;
                end
            end
            else
            begin
                rem_next = REM_W'(WORD_SLOTS);
                for (int g = 0; g < GROUPS; g++)
                begin
                    for (int k = 0; k < GROUP_WORDS; k++)
                    begin
                        if ((grp_reg == 2'(g)) && (idx_reg == 3'(k)))
                        begin
                            extra_next[g][2*k +: 2] = extra_reg[g][2*k +: 2]
                                                      | s_tdata[WORD_W-1 -: 2];
                        end
                    end
                end
                if (idx_reg == 3'(GROUP_WORDS - 1))
                begin
                    idx_next = '0;
                    grp_next = grp_reg + 2'd1;
                end
                else
                begin
                    idx_next = idx_reg + 3'd1;
                end
            end
        end

        if (mark_status.clear_done)
        begin
            wait_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg   <= '0;
            final_reg <= 1'b0;
            wait_reg  <= 1'b0;
            grp_reg   <= '0;
            idx_reg   <= '0;
            for (int g = 0; g < GROUPS; g++)
            begin
                extra_reg[g] <= '0;
            end
        end
        else
        begin
            rem_reg   <= rem_next;
            final_reg <= final_next;
            wait_reg  <= wait_next;
            grp_reg   <= grp_next;
            idx_reg   <= idx_next;
            extra_reg <= extra_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

endmodule

>>> rtl/core/hsp_mark.sv
// Bitmap stage: read-modify-write of the position bitmap, selection against the
// target weight, hold-back of the final result and the clearing sequencer.
// Depends on hsp_pkg and hsp_ram.
module hsp_mark (
    input  logic                          clk,
    input  logic                          rst_n,
    input  hsp_pkg::token_t               token,
    input  logic [hsp_pkg::COUNT_W-1:0]   target,
    output logic                          res_push,
    output hsp_pkg::result_t              res,
    output hsp_pkg::mark_status_t         status
);
    import hsp_pkg::*;

    typedef enum logic [1:0] {
        CLR_ALL,
        IDLE,
        CLR_LIST
    } clr_state_t;

    clr_state_t         state_reg, state_next;
    token_t             tok_reg;
    logic [COUNT_W-1:0] found_reg, found_next;
    logic               pend_valid_reg, pend_valid_next;
    logic [POS_W-1:0]   pend_pos_reg, pend_pos_next;
    logic               fwd_valid_reg, fwd_valid_next;
    logic [POS_W-1:0]   fwd_addr_reg, fwd_addr_next;
    logic [POS_W-1:0]   clr_addr_reg, clr_addr_next;
    logic [LIST_AW-1:0] clr_idx_reg, clr_idx_next;
    logic               rd_pend_reg, rd_pend_next;
    logic               done_reg, done_next;

    logic               bm_we;
    logic [POS_W-1:0]   bm_waddr;
    logic [0:0]         bm_wdata;
    logic [0:0]         bm_rdata;
    logic [POS_W-1:0]   list_rdata;
    logic               marked;
    logic               cand;
    logic               hit;
    logic               finish;
    logic               fail;

    hsp_ram #(
        .WIDTH (1),
        .DEPTH (VECTOR_SIZE)
    ) u_bitmap (
        .clk   (clk),
        .we    (bm_we),
        .waddr (bm_waddr),
        .wdata (bm_wdata),
        .raddr (token.pos),
        .rdata (bm_rdata)
    );

    hsp_ram #(
        .WIDTH (POS_W),
        .DEPTH (LIST_DEPTH)
    ) u_list (
        .clk   (clk),
        .we    (hit),
        .waddr (found_reg),
        .wdata (tok_reg.pos),
        .raddr (clr_idx_reg),
        .rdata (list_rdata)
    );

    always_comb
    begin
        marked = bm_rdata[0] | (fwd_valid_reg && (fwd_addr_reg == tok_reg.pos));
        cand   = tok_reg.valid && (tok_reg.kind != TOK_FINISH);
        hit    = cand && (found_reg < target) && !marked;
        finish = tok_reg.valid && (tok_reg.kind == TOK_FINISH);
        fail   = found_reg < target;

        res_push = 1'b0;
        res      = '0;
        pend_valid_next = pend_valid_reg;
        pend_pos_next   = pend_pos_reg;
        found_next      = found_reg;
        fwd_valid_next  = hit;
        fwd_addr_next   = tok_reg.pos;

        if (hit)
        begin
            found_next = found_reg + COUNT_W'(1);
            if (tok_reg.kind == TOK_FINAL)
            begin
                res_push        = pend_valid_reg;
                res.position    = pend_pos_reg;
                res.position_valid = 1'b1;
                pend_valid_next = 1'b1;
                pend_pos_next   = tok_reg.pos;
            end
            else
            begin
                res_push           = 1'b1;
                res.position       = tok_reg.pos;
                res.position_valid = 1'b1;
            end
        end
        else if (finish)
        begin
            res_push           = 1'b1;
            res.position       = pend_valid_reg ? pend_pos_reg : '0;
            res.position_valid = pend_valid_reg;
            res.last           = 1'b1;
            res.failed         = fail;
            pend_valid_next    = 1'b0;
        end

        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        clr_idx_next  = clr_idx_reg;
        rd_pend_next  = 1'b0;
        done_next     = 1'b0;
        bm_we         = 1'b0;
        bm_waddr      = tok_reg.pos;
        bm_wdata      = 1'b0;

        unique case (state_reg)
            CLR_ALL:
            begin
                bm_we         = 1'b1;
                bm_waddr      = clr_addr_reg;
                clr_addr_next = clr_addr_reg + POS_W'(1);
                if (clr_addr_reg == POS_W'(VECTOR_SIZE - 1))
                begin
                    state_next = IDLE;
                end
            end
            IDLE:
            begin
                bm_we    = hit;
                bm_wdata = 1'b1;
                if (finish)
                begin
                    state_next   = CLR_LIST;
                    clr_idx_next = '0;
                end
            end
            CLR_LIST:
            begin
                bm_we    = rd_pend_reg;
                bm_waddr = list_rdata;
                if (clr_idx_reg < found_reg)
                begin
                    clr_idx_next = clr_idx_reg + LIST_AW'(1);
                    rd_pend_next = 1'b1;
                end
                else if (!rd_pend_reg)
                begin
                    state_next = IDLE;
                    found_next = '0;
                    done_next  = 1'b1;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase

        status.busy       = (state_reg == CLR_ALL);
        status.clear_done = done_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= CLR_ALL;
            tok_reg        <= '0;
            found_reg      <= '0;
            pend_valid_reg <= 1'b0;
            fwd_valid_reg  <= 1'b0;
            clr_addr_reg   <= '0;
            clr_idx_reg    <= '0;
            rd_pend_reg    <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            tok_reg        <= token;
            found_reg      <= found_next;
            pend_valid_reg <= pend_valid_next;
            fwd_valid_reg  <= fwd_valid_next;
            clr_addr_reg   <= clr_addr_next;
            clr_idx_reg    <= clr_idx_next;
            rd_pend_reg    <= rd_pend_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_pos_reg <= pend_pos_next;
        fwd_addr_reg <= fwd_addr_next;
    end

endmodule

>>> rtl/core/hsp_out_fifo.sv
// Result queue between the bitmap stage and the output stream.
// Depends on hsp_pkg.
module hsp_out_fifo (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  hsp_pkg::result_t              push_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output hsp_pkg::result_t              pop_data,
    output logic                          room,
    output logic [hsp_pkg::FIFO_CW-1:0]   level
);
    import hsp_pkg::*;

    result_t            mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CW-1:0] count_reg, count_next;
    logic               pop;

    always_comb
    begin
        m_valid     = (count_reg != '0);
        pop         = m_valid && m_ready;
        pop_data    = mem_reg[rd_ptr_reg];
        room        = (count_reg <= FIFO_CW'(FIFO_DEPTH - 2));
        level       = count_reg;
        wr_ptr_next = push ? wr_ptr_reg + FIFO_AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + FIFO_AW'(1) : rd_ptr_reg;
        count_next  = count_reg + FIFO_CW'(push) - FIFO_CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/core/hash_to_sparse_positions.sv
// Top level of the hash to sparse positions block: configuration register,
// input stage, bitmap stage and result queue. Depends on hsp_pkg, hsp_feed,
// hsp_mark and hsp_out_fifo.
//
// A hash arrives as sixteen 32-bit beats. Every candidate position takes a turn
// on the single read-modify-write path of the 1024-entry bitmap RAM, so each of
// words 0 to 14 carries three candidates and the next word is accepted as the
// last of them is issued. Word 15 carries six candidates and the closing result,
// after which the bitmap is cleared by walking the list of selected positions
// before the first word of the next hash is accepted. After reset the block
// clears every entry of the bitmap before it takes its first beat; the
// configuration channel is always ready. Results queue in a four-deep buffer,
// and candidate issue also stalls while that buffer is nearly full.
module hash_to_sparse_positions (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [hsp_pkg::COUNT_W-1:0]    cfg_data,   // target_weight
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [hsp_pkg::WORD_W-1:0]     s_tdata,    // hash_word
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [hsp_pkg::M_DATA_W-1:0]   m_tdata,    // position, zero fill
    output logic [hsp_pkg::M_USER_W-1:0]   m_tuser,    // position_valid, failed
    output logic                           m_tlast
);
    import hsp_pkg::*;

    logic [COUNT_W-1:0] target_reg;
    token_t             token;
    mark_status_t       mark_status;
    logic               res_push;
    result_t            res;
    result_t            out_res;
    logic               room;
    logic [FIFO_CW-1:0] fifo_level;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= TARGET_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            target_reg <= cfg_data;
        end
    end

    hsp_feed u_feed (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .room        (room),
        .mark_status (mark_status),
        .token       (token)
    );

    hsp_mark u_mark (
        .clk      (clk),
        .rst_n    (rst_n),
        .token    (token),
        .target   (target_reg),
        .res_push (res_push),
        .res      (res),
        .status   (mark_status)
    );

    hsp_out_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (res),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .pop_data  (out_res),
        .room      (room),
        .level     (fifo_level)
    );

    assign m_tdata = M_DATA_W'(out_res.position);
    assign m_tuser = {out_res.failed, out_res.position_valid};
    assign m_tlast = out_res.last;

    a_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
        !(res_push && (fifo_level == FIFO_CW'(FIFO_DEPTH)) && !(m_tvalid && m_tready)))
        else $error("result queue overflow");

    a_quiet_while_clearing : assert property (@(posedge clk) disable iff (!rst_n)
        mark_status.busy |-> (!s_tready && !token.valid))
        else $error("input taken during bitmap clearing");

    a_empty_only_last : assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && !res.position_valid) |-> res.last)
        else $error("empty result that is not the closing beat");

endmodule
